@@ rtl/ecm_pkg.sv @@
`default_nettype none
package ecm_pkg;

   typedef enum logic [1:0] {
      STATUS_FACTOR   = 2'd0,
      STATUS_INFINITY = 2'd1,
      STATUS_LIMIT    = 2'd2
   } status_type;

   // datapath operations, one per command from the controller
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,     // latch item, start reduction of a
      OP_RED_X,    // reduce start_x
      OP_RED_Y,    // reduce start_y
      OP_DENOM,    // form u and v for this step
      OP_GCD,      // extended Euclid on v
      OP_COFACTOR, // n / g
      OP_SLOPE,    // m = inv * u
      OP_SQ,       // m * m
      OP_RX,       // rx = sq - px - qx
      OP_MY,       // m * (px - rx)
      OP_RY,       // ry = prod - py, commit Q
      OP_DBL_SQ    // px * px for doubling numerator
   } op_type;

   typedef struct packed {
      op_type op;
      logic   go;
   } cmd_type;

   typedef struct packed {
      logic done;      // op finished (pulse)
      logic n_small;   // modulus below two
      logic is_double; // P equals Q
      logic v_zero;
      logic g_one;
   } stat_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RED_A,
      ST_RED_X,
      ST_RED_Y,
      ST_CHECK,
      ST_DBL_SQ,
      ST_DENOM,
      ST_GCD,
      ST_COFACTOR,
      ST_SLOPE,
      ST_SQ,
      ST_RX,
      ST_MY,
      ST_RY,
      ST_DONE
   } state_type;

endpackage
`default_nettype wire

@@ rtl/ecm_divider.sv @@
`default_nettype none
// restoring divider, one quotient bit per cycle; numerator up to 2*W bits
module ecm_divider #(
   parameter int W = 63
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           start,
   input  wire logic [2*W-1:0] num,
   input  wire logic [W-1:0]   den,
   output logic                done,
   output logic [2*W-1:0]      quot,
   output logic [W-1:0]        rem
);
   localparam int CW = $clog2(2*W+1);

   logic [2*W-1:0] quot_ff, quot_in;
   logic [W:0]     rem_ff, rem_in;
   logic [W-1:0]   den_ff, den_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic           busy_ff, busy_in;
   logic           done_ff, done_in;
   logic [W:0]     trial;

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = '0;
      if (start) begin
         quot_in = num;
         rem_in  = '0;
         den_in  = den;
         cnt_in  = CW'(2*W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         trial = {rem_ff[W-1:0], quot_ff[2*W-1]};
         if (trial >= {1'b0, den_ff}) begin
            rem_in  = trial - {1'b0, den_ff};
            quot_in = {quot_ff[2*W-2:0], 1'b1};
         end else begin
            rem_in  = trial;
            quot_in = {quot_ff[2*W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;
   assign rem  = rem_ff[W-1:0];
endmodule
`default_nettype wire

@@ rtl/ecm_datapath.sv @@
`default_nettype none
module ecm_datapath #(
   parameter int NUM_WIDTH = 63
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire ecm_pkg::cmd_type       cmd,
   input  wire logic [NUM_WIDTH-1:0]   in_modulus,
   input  wire logic [NUM_WIDTH-1:0]   in_coeff,
   input  wire logic [NUM_WIDTH-1:0]   in_x,
   input  wire logic [NUM_WIDTH-1:0]   in_y,
   output ecm_pkg::stat_type           stat,
   output logic [NUM_WIDTH-1:0]        factor,
   output logic [NUM_WIDTH-1:0]        cofactor
);
   import ecm_pkg::*;
   localparam int W = NUM_WIDTH;

   logic [W-1:0] n_ff, a_ff, px_ff, py_ff, qx_ff, qy_ff;
   logic [W-1:0] rx_ff, yin_ff, xin_ff, u_ff, v_ff, m_ff, sq_ff;
   logic [W-1:0] r0_ff, r1_ff, t0_ff, t1_ff;
   logic [W-1:0] cof_ff;
   logic [1:0]   gph_ff;    // extended Euclid phase
   logic         gbusy_ff;
   logic         gstart_ff;
   logic         mwait_ff;  // a product is being reduced
   logic         done_ff;
   op_type       op_ff;     // multiplication/division in flight

   // shared divider: products mod n, reductions, Euclid quotients
   logic           dv_start;
   logic [2*W-1:0] dv_num;
   logic [W-1:0]   dv_den;
   logic           dv_done;
   logic [2*W-1:0] dv_quot;
   logic [W-1:0]   dv_rem;

   // one multiplier: 32x32 partial products accumulated in turn
   logic [W-1:0]   mul_a, mul_b;
   logic [63:0]    ma_ff, mb_ff;
   logic [1:0]     mph_ff;
   logic           mbusy_ff;
   logic [31:0]    pp_a, pp_b;
   logic [63:0]    pp;
   logic [127:0]   pp_sh;
   logic [127:0]   prod_ff;
   logic           mul_vld_ff;
   logic           mul_go;

   ecm_divider #(.W(W)) u_div (
      .clock(clock), .reset(reset), .start(dv_start), .num(dv_num), .den(dv_den),
      .done(dv_done), .quot(dv_quot), .rem(dv_rem)
   );

   function automatic logic [W-1:0] msub(input logic [W-1:0] x, input logic [W-1:0] y,
                                         input logic [W-1:0] m);
      logic [W:0] s;
      s = {1'b0, x} - {1'b0, y};
      if (x < y) s = s + {1'b0, m};
      return s[W-1:0];
   endfunction

   function automatic logic [W-1:0] madd(input logic [W-1:0] x, input logic [W-1:0] y,
                                         input logic [W-1:0] m);
      logic [W:0] s;
      s = {1'b0, x} + {1'b0, y};
      if (s >= {1'b0, m}) s = s - {1'b0, m};
      return s[W-1:0];
   endfunction

   // Euclid phases: 0 divide r0/r1, 1 wait quotient, 3 wait q mod n or product, 2 q mod n times t1
   // multiplier operands
   always_comb begin
      mul_go = 1'b0;
      mul_a  = '0;
      mul_b  = '0;
      if (cmd.go) begin
         case (cmd.op)
            OP_DBL_SQ: begin mul_go = 1'b1; mul_a = px_ff; mul_b = px_ff; end
            OP_SLOPE:  begin mul_go = 1'b1; mul_a = t0_ff; mul_b = u_ff; end
            OP_SQ:     begin mul_go = 1'b1; mul_a = m_ff;  mul_b = m_ff; end
            OP_MY:     begin mul_go = 1'b1; mul_a = m_ff;  mul_b = msub(px_ff, rx_ff, n_ff); end
            default: ;
         endcase
      end else if (gbusy_ff && gph_ff == 2'd2) begin
         mul_go = 1'b1;
         mul_a  = dv_rem;   // q mod n
         mul_b  = t1_ff;
      end
   end

   // phase bit 0 picks the half of a, bit 1 the half of b
   always_comb begin
      pp_a = mph_ff[0] ? ma_ff[63:32] : ma_ff[31:0];
      pp_b = mph_ff[1] ? mb_ff[63:32] : mb_ff[31:0];
      pp   = pp_a * pp_b;
      case (mph_ff)
         2'd0:       pp_sh = {64'd0, pp};
         2'd1, 2'd2: pp_sh = {32'd0, pp, 32'd0};
         default:    pp_sh = {pp, 64'd0};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_vld_ff <= 1'b0;
         mbusy_ff   <= 1'b0;
         mph_ff     <= 2'd0;
      end else begin
         mul_vld_ff <= 1'b0;
         if (mul_go) begin
            mbusy_ff <= 1'b1;
            mph_ff   <= 2'd0;
         end else if (mbusy_ff) begin
            mph_ff <= mph_ff + 2'd1;
            if (mph_ff == 2'd3) begin
               mbusy_ff   <= 1'b0;
               mul_vld_ff <= 1'b1;
            end
         end
      end
      if (mul_go) begin
         ma_ff   <= 64'(mul_a);
         mb_ff   <= 64'(mul_b);
         prod_ff <= '0;
      end else if (mbusy_ff) begin
         prod_ff <= prod_ff + pp_sh;
      end
   end

   // divider start select
   logic [W-1:0] q_keep_ff;
   always_comb begin
      dv_start = 1'b0;
      dv_num   = '0;
      dv_den   = n_ff;
      if (cmd.go) begin
         case (cmd.op)
            OP_LOAD:     begin dv_start = 1'b1; dv_num = {{W{1'b0}}, in_coeff};
                               dv_den = in_modulus; end
            OP_RED_X:    begin dv_start = 1'b1; dv_num = {{W{1'b0}}, xin_ff}; end
            OP_RED_Y:    begin dv_start = 1'b1; dv_num = {{W{1'b0}}, yin_ff}; end
            OP_GCD:      begin dv_start = 1'b1; dv_num = {{W{1'b0}}, n_ff};
                               dv_den = v_ff; end
            OP_COFACTOR: begin dv_start = 1'b1; dv_num = {{W{1'b0}}, n_ff};
                               dv_den = r0_ff; end
            default: ;
         endcase
      end else if (mul_vld_ff) begin
         dv_start = 1'b1;
         dv_num   = prod_ff[2*W-1:0];
      end else if (gbusy_ff && gph_ff == 2'd1 && dv_done) begin
         // reduce quotient mod n
         dv_start = 1'b1;
         dv_num   = dv_quot;
      end else if (gbusy_ff && gph_ff == 2'd0 && gstart_ff) begin
         dv_start = 1'b1;
         dv_num   = {{W{1'b0}}, r0_ff};
         dv_den   = r1_ff;
      end
   end

   logic [W-1:0] u_calc, v_calc;
   always_comb begin
      if (px_ff == qx_ff && py_ff == qy_ff) begin
         u_calc = madd(madd(madd(sq_ff, sq_ff, n_ff), sq_ff, n_ff), a_ff, n_ff);
         v_calc = madd(py_ff, py_ff, n_ff);
      end else begin
         u_calc = msub(py_ff, qy_ff, n_ff);
         v_calc = msub(px_ff, qx_ff, n_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gbusy_ff  <= 1'b0;
         gph_ff    <= 2'd0;
         gstart_ff <= 1'b0;
         done_ff   <= 1'b0;
         mwait_ff  <= 1'b0;
         op_ff     <= OP_NONE;
      end else begin
         done_ff   <= 1'b0;
         gstart_ff <= 1'b0;
         if (cmd.go) begin
            op_ff <= cmd.op;
            case (cmd.op)
               OP_DENOM: done_ff <= 1'b1;
               OP_RX:    done_ff <= 1'b1;
               OP_RY:    done_ff <= 1'b1;
               OP_GCD:   begin gbusy_ff <= 1'b1; gph_ff <= 2'd1; end
               default: ;
            endcase
         end
         if (mul_vld_ff) mwait_ff <= 1'b1;
         if (gbusy_ff) begin
            case (gph_ff)
               2'd0: if (gstart_ff) gph_ff <= 2'd1;
                     else if (r1_ff == '0) begin
                        gbusy_ff <= 1'b0;
                        done_ff  <= 1'b1;
                     end else gstart_ff <= 1'b1;
               2'd1: if (dv_done) gph_ff <= 2'd3;
               2'd3: if (dv_done) gph_ff <= 2'd2;
               2'd2: gph_ff <= 2'd3;
               default: ;
            endcase
            if (gph_ff == 2'd3 && dv_done && mwait_ff) begin
               mwait_ff <= 1'b0;
               gph_ff   <= 2'd0;
            end
         end else if (!cmd.go && dv_done && !gbusy_ff) begin
            done_ff  <= 1'b1;
            mwait_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.go) begin
         case (cmd.op)
            OP_LOAD: begin
               n_ff   <= in_modulus;
               xin_ff <= in_x;
               yin_ff <= in_y;
            end
            OP_DENOM: begin
               u_ff <= u_calc;
               v_ff <= v_calc;
            end
            OP_GCD: begin
               r0_ff <= n_ff;
               r1_ff <= v_ff;
               t0_ff <= '0;
               t1_ff <= {{(W-1){1'b0}}, 1'b1};
            end
            OP_RX: begin
               rx_ff <= msub(msub(sq_ff, px_ff, n_ff), qx_ff, n_ff);
            end
            OP_RY: begin
               qx_ff <= rx_ff;
               qy_ff <= msub(sq_ff, py_ff, n_ff);
            end
            default: ;
         endcase
      end
      if (gbusy_ff && gph_ff == 2'd1 && dv_done) begin
         // quotient in dv_quot, remainder r2 in dv_rem
         q_keep_ff <= dv_rem;
      end
      if (gbusy_ff && gph_ff == 2'd3 && dv_done && mwait_ff) begin
         r0_ff <= r1_ff;
         r1_ff <= q_keep_ff;
         t0_ff <= t1_ff;
         t1_ff <= msub(t0_ff, dv_rem, n_ff);
      end
      if (!gbusy_ff && !cmd.go && dv_done) begin
         case (op_ff)
            OP_LOAD:     a_ff   <= dv_rem;
            OP_RED_X:    begin px_ff <= dv_rem; qx_ff <= dv_rem; end
            OP_RED_Y:    begin py_ff <= dv_rem; qy_ff <= dv_rem; end
            OP_DBL_SQ:   sq_ff  <= dv_rem;
            OP_SLOPE:    m_ff   <= dv_rem;
            OP_SQ:       sq_ff  <= dv_rem;
            OP_MY:       sq_ff  <= dv_rem;
            OP_COFACTOR: cof_ff <= dv_quot[W-1:0];
            default: ;
         endcase
      end
   end

   assign stat.done      = done_ff;
   assign stat.n_small   = (n_ff < W'(2));
   assign stat.is_double = (px_ff == qx_ff) && (py_ff == qy_ff);
   assign stat.v_zero    = (v_ff == '0);
   assign stat.g_one     = (r0_ff == W'(1));
   assign factor         = r0_ff;
   assign cofactor       = cof_ff;
endmodule
`default_nettype wire

@@ rtl/ecm_control.sv @@
`default_nettype none
module ecm_control #(
   parameter int ITER_WIDTH = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic                  n_small_in,
   input  wire logic [ITER_WIDTH-1:0] limit,
   input  wire ecm_pkg::stat_type     stat,
   output ecm_pkg::cmd_type           cmd,
   output logic                       busy,
   output logic                       rsp_valid,
   output ecm_pkg::status_type        rsp_status,
   output logic [ITER_WIDTH-1:0]      rsp_steps
);
   import ecm_pkg::*;

   state_type             state_ff, state_in;
   logic [ITER_WIDTH-1:0] steps_ff, steps_in, limit_ff;
   status_type            status_ff, status_in;
   logic                  issued_ff;

   // command is issued once on entry to a state
   always_comb begin
      state_in  = state_ff;
      steps_in  = steps_ff;
      status_in = status_ff;
      case (state_ff)
         ST_IDLE: if (start) begin
            steps_in = '0;
            if (n_small_in) begin
               status_in = STATUS_INFINITY;
               state_in  = ST_DONE;
            end else state_in = ST_RED_A;
         end
         ST_RED_A: if (stat.done) state_in = ST_RED_X;
         ST_RED_X: if (stat.done) state_in = ST_RED_Y;
         ST_RED_Y: if (stat.done) state_in = ST_CHECK;
         ST_CHECK: if (steps_ff == limit_ff) begin
            status_in = STATUS_LIMIT;
            state_in  = ST_DONE;
         end else if (stat.is_double) state_in = ST_DBL_SQ;
         else state_in = ST_DENOM;
         ST_DBL_SQ: if (stat.done) state_in = ST_DENOM;
         ST_DENOM: if (stat.done) state_in = ST_GCD;
         ST_GCD: if (issued_ff && stat.v_zero) begin
            status_in = STATUS_INFINITY;
            state_in  = ST_DONE;
         end else if (stat.done) begin
            if (stat.g_one) state_in = ST_SLOPE;
            else begin
               status_in = STATUS_FACTOR;
               state_in  = ST_COFACTOR;
            end
         end
         ST_COFACTOR: if (stat.done) state_in = ST_DONE;
         ST_SLOPE: if (stat.done) state_in = ST_SQ;
         ST_SQ: if (stat.done) state_in = ST_RX;
         ST_RX: if (stat.done) state_in = ST_MY;
         ST_MY: if (stat.done) state_in = ST_RY;
         ST_RY: if (stat.done) begin
            steps_in = steps_ff + 1'b1;
            state_in = ST_CHECK;
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd.go = 1'b0;
      cmd.op = OP_NONE;
      case (state_ff)
         ST_IDLE:     begin cmd.go = start; cmd.op = OP_LOAD; end
         ST_RED_A:    begin cmd.go = stat.done; cmd.op = OP_RED_X; end
         ST_RED_X:    begin cmd.go = stat.done; cmd.op = OP_RED_Y; end
         ST_CHECK:    begin
            cmd.go = (steps_ff != limit_ff);
            cmd.op = stat.is_double ? OP_DBL_SQ : OP_DENOM;
         end
         ST_DBL_SQ:   begin cmd.go = stat.done; cmd.op = OP_DENOM; end
         ST_DENOM:    begin cmd.go = stat.done && !stat.v_zero; cmd.op = OP_GCD; end
         ST_GCD:      begin
            cmd.go = stat.done && !issued_ff;
            cmd.op = OP_NONE;
            if (!issued_ff) cmd.go = 1'b0;
            else if (stat.done) begin
               cmd.go = 1'b1;
               cmd.op = stat.g_one ? OP_SLOPE : OP_COFACTOR;
            end
         end
         ST_SLOPE:    begin cmd.go = stat.done; cmd.op = OP_SQ; end
         ST_SQ:       begin cmd.go = stat.done; cmd.op = OP_RX; end
         ST_RX:       begin cmd.go = stat.done; cmd.op = OP_MY; end
         ST_MY:       begin cmd.go = stat.done; cmd.op = OP_RY; end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         steps_ff  <= '0;
         status_ff <= STATUS_LIMIT;
         limit_ff  <= '0;
         issued_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         steps_ff  <= steps_in;
         status_ff <= status_in;
         if (state_ff == ST_IDLE && start) limit_ff <= limit;
         // v_zero is valid once DENOM completes; issued_ff is registered from ST_GCD
         issued_ff <= (state_ff == ST_GCD);
         if (state_ff == ST_DENOM && stat.done && stat.v_zero) issued_ff <= 1'b0;
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_valid  = (state_ff == ST_DONE);
   assign rsp_status = status_ff;
   assign rsp_steps  = steps_ff;
endmodule
`default_nettype wire

@@ rtl/ecm_curve_multiple_factor_search_unit.sv @@
`default_nettype none
// Elliptic-curve factor search, one curve per word.
// Input: pulse start with req_* valid while busy is low; the word is taken
// at that edge and busy rises until the result has been presented.
// Output: rsp_strobe is high for one cycle with rsp_status, rsp_factor,
// rsp_cofactor and rsp_steps_used; the receiver cannot stall it.
// Config: csr_we writes csr_wdata into the step limit (reset 1000). Write
// only while busy is low.
// Divider use: products, reductions and Euclid quotients all pass through one
// restoring divider (products first pass a four-phase multiplier). A word
// starts with three reductions; each step then needs 3*k + 3 divider passes,
// one more when doubling, where k is the Euclid iteration count. A step that
// finds a factor ends after Euclid with one pass for the cofactor instead of
// the last three; a modulus below two is answered without waiting on the
// divider. A word takes up to limit steps. One word at a time; start is only
// taken while busy is low.
// Reset: synchronous, returns to idle and restores the limit.
module ecm_curve_multiple_factor_search_unit #(
   parameter int NUM_WIDTH  = 63,
   parameter int ITER_WIDTH = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic [NUM_WIDTH-1:0]  req_modulus,
   input  wire logic [NUM_WIDTH-1:0]  req_curve_coeff,
   input  wire logic [NUM_WIDTH-1:0]  req_start_x,
   input  wire logic [NUM_WIDTH-1:0]  req_start_y,
   output logic                       rsp_strobe,
   output logic [1:0]                 rsp_status,
   output logic [NUM_WIDTH-1:0]       rsp_factor,
   output logic [NUM_WIDTH-1:0]       rsp_cofactor,
   output logic [ITER_WIDTH-1:0]      rsp_steps_used,
   input  wire logic                  csr_we,
   input  wire logic [ITER_WIDTH-1:0] csr_wdata
);
   import ecm_pkg::*;

   logic [ITER_WIDTH-1:0] limit_ff;
   cmd_type               cmd;
   stat_type              stat;
   status_type            st;
   logic [NUM_WIDTH-1:0]  fac, cof;

   always_ff @(posedge clock) begin
      if (reset) limit_ff <= ITER_WIDTH'(1000);
      else if (csr_we) limit_ff <= csr_wdata;
   end

   ecm_control #(.ITER_WIDTH(ITER_WIDTH)) u_ctl (
      .clock(clock), .reset(reset), .start(start),
      .n_small_in(req_modulus < NUM_WIDTH'(2)), .limit(limit_ff), .stat(stat),
      .cmd(cmd), .busy(busy), .rsp_valid(rsp_strobe), .rsp_status(st),
      .rsp_steps(rsp_steps_used)
   );

   ecm_datapath #(.NUM_WIDTH(NUM_WIDTH)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .in_modulus(req_modulus),
      .in_coeff(req_curve_coeff), .in_x(req_start_x), .in_y(req_start_y),
      .stat(stat), .factor(fac), .cofactor(cof)
   );

   assign rsp_status   = st;
   assign rsp_factor   = (st == STATUS_FACTOR) ? fac : '0;
   assign rsp_cofactor = (st == STATUS_FACTOR) ? cof : '0;
endmodule
`default_nettype wire
